[hw/rtl/tpqd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the two-axis PID quadrant drive.
// No dependencies; every other file but tpqd_in_if takes names from here by scope.

package tpqd_pkg;

  localparam int CENTER_BITS = 12;
  localparam int GAIN_BITS   = 16;
  localparam int DRIVE_BITS  = 10;
  localparam int WORD_BITS   = 11;
  localparam int CFG_BITS    = 16;
  localparam int INDEX_BITS  = 3;
  localparam int FRAC_BITS   = 8;

  localparam logic [DRIVE_BITS-1:0]  DRIVE_MAX      = 10'd1023;
  localparam logic [CENTER_BITS-1:0] CENTER_X_RESET = 12'd320;
  localparam logic [CENTER_BITS-1:0] CENTER_Y_RESET = 12'd240;
  localparam logic [GAIN_BITS-1:0]   GAIN_P_RESET   = 16'd256;
  localparam logic [GAIN_BITS-1:0]   GAIN_I_RESET   = 16'd0;
  localparam logic [GAIN_BITS-1:0]   GAIN_D_RESET   = 16'd0;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_GAIN_P   = 3'd2,
    REG_GAIN_I   = 3'd3,
    REG_GAIN_D   = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    Q_NONE  = 3'd0,
    Q_ONE   = 3'd1,
    Q_TWO   = 3'd2,
    Q_THREE = 3'd3,
    Q_FOUR  = 3'd4
  } quad_t;

  typedef struct packed {
    logic signed [GAIN_BITS-1:0] p;
    logic signed [GAIN_BITS-1:0] i;
    logic signed [GAIN_BITS-1:0] d;
  } gains_t;

  typedef struct packed {
    logic acc;
    logic e1;
    logic e2;
    logic e3;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/tpqd_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Input channel: one tracked target position and enable per transaction.
// Standalone interface, no package use.

interface tpqd_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] target_x;
  logic [COORD_BITS-1:0] target_y;
  logic                  drive_enable;

  modport source (output valid, output target_x, output target_y, output drive_enable,
                  input ready);
  modport sink   (input valid, input target_x, input target_y, input drive_enable,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/tpqd_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// Output channel: four motor words and the quadrant code per transaction.
// Field widths come from tpqd_pkg.

interface tpqd_out_if;
  logic                           valid;
  logic                           ready;
  logic [tpqd_pkg::WORD_BITS-1:0] motor0_word;
  logic [tpqd_pkg::WORD_BITS-1:0] motor1_word;
  logic [tpqd_pkg::WORD_BITS-1:0] motor2_word;
  logic [tpqd_pkg::WORD_BITS-1:0] motor3_word;
  logic [2:0]                     quadrant;

  modport source (output valid, output motor0_word, output motor1_word,
                  output motor2_word, output motor3_word, output quadrant, input ready);
  modport sink   (input valid, input motor0_word, input motor1_word,
                  input motor2_word, input motor3_word, input quadrant, output ready);
endinterface

`default_nettype wire

[hw/rtl/two_axis_pid_quadrant_drive_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Two-axis PID quadrant drive: x and y lanes in parallel, merged into motor words.
// Depends on tpqd_pkg, tpqd_in_if, tpqd_out_if, tpqd_lane and tpqd_merge.
//
// One transaction carries a target position and an enable flag and returns
// four motor words and a quadrant code. A new transaction is taken every cycle
// while no stall holds the input; each one passes through error and running
// sum, the three gain multipliers, the add and clamp, and the output register
// that forms the words. The running sums and last errors update when an enabled
// transaction is accepted, so consecutive transactions never wait on each
// other. Every stage holds its own valid bit, so a stalled output only stops
// the stages behind it once they fill. Write configuration only while idle.

module two_axis_pid_quadrant_drive_unit #(
  parameter int COORD_BITS = 12,
  parameter int SUM_BITS   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  tpqd_in_if.sink                                  in,
  tpqd_out_if.source                               out,
  input  wire logic                                cfg_we,
  input  wire logic [tpqd_pkg::INDEX_BITS-1:0]     cfg_index,
  input  wire logic [tpqd_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int XW = (COORD_BITS > tpqd_pkg::CENTER_BITS) ? COORD_BITS
                                                           : tpqd_pkg::CENTER_BITS;

  logic [tpqd_pkg::CENTER_BITS-1:0] center_x;
  logic [tpqd_pkg::CENTER_BITS-1:0] center_y;
  tpqd_pkg::gains_t                 gains;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= tpqd_pkg::CENTER_X_RESET;
      center_y <= tpqd_pkg::CENTER_Y_RESET;
      gains.p  <= tpqd_pkg::GAIN_P_RESET;
      gains.i  <= tpqd_pkg::GAIN_I_RESET;
      gains.d  <= tpqd_pkg::GAIN_D_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpqd_pkg::REG_CENTER_X: center_x <= cfg_data[tpqd_pkg::CENTER_BITS-1:0];
        tpqd_pkg::REG_CENTER_Y: center_y <= cfg_data[tpqd_pkg::CENTER_BITS-1:0];
        tpqd_pkg::REG_GAIN_P:   gains.p  <= cfg_data;
        tpqd_pkg::REG_GAIN_I:   gains.i  <= cfg_data;
        tpqd_pkg::REG_GAIN_D:   gains.d  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;
  tpqd_pkg::pipe_ctrl_t ctrl;

  assign r4       = !v4 || out.ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in.ready = r1;

  assign ctrl.acc = in.valid && r1 && in.drive_enable;
  assign ctrl.e1  = r1;
  assign ctrl.e2  = r2;
  assign ctrl.e3  = r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  logic [XW-1:0]   tx, ty, cx, cy;
  tpqd_pkg::quad_t q_next, q1, q2, q3;

  always_comb begin
    tx = XW'(in.target_x);
    ty = XW'(in.target_y);
    cx = XW'(center_x);
    cy = XW'(center_y);
    priority if (!in.drive_enable)      q_next = tpqd_pkg::Q_NONE;
    else if (tx >= cx && ty >= cy)      q_next = tpqd_pkg::Q_ONE;
    else if (tx <  cx && ty >  cy)      q_next = tpqd_pkg::Q_TWO;
    else if (tx <= cx && ty <= cy)      q_next = tpqd_pkg::Q_THREE;
    else if (tx >  cx && ty <  cy)      q_next = tpqd_pkg::Q_FOUR;
    else                                q_next = tpqd_pkg::Q_NONE;
  end

  always_ff @(posedge clk) begin
    if (ctrl.e1) q1 <= q_next;
    if (ctrl.e2) q2 <= q1;
    if (ctrl.e3) q3 <= q2;
  end

  logic [tpqd_pkg::DRIVE_BITS-1:0] drive_x, drive_y;

  tpqd_lane #(
    .COORD_BITS   (COORD_BITS),
    .SUM_BITS     (SUM_BITS),
    .CENTER_RESET (int'(tpqd_pkg::CENTER_X_RESET))
  ) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .target (in.target_x),
    .center (center_x),
    .gains  (gains),
    .drive  (drive_x)
  );

  tpqd_lane #(
    .COORD_BITS   (COORD_BITS),
    .SUM_BITS     (SUM_BITS),
    .CENTER_RESET (int'(tpqd_pkg::CENTER_Y_RESET))
  ) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .target (in.target_y),
    .center (center_y),
    .gains  (gains),
    .drive  (drive_y)
  );

  logic [tpqd_pkg::WORD_BITS-1:0] w0_next, w1_next, w2_next, w3_next;

  tpqd_merge u_merge (
    .drive_x (drive_x),
    .drive_y (drive_y),
    .quad    (q3),
    .word0   (w0_next),
    .word1   (w1_next),
    .word2   (w2_next),
    .word3   (w3_next)
  );

  always_ff @(posedge clk) begin
    if (r4) begin
      out.motor0_word <= w0_next;
      out.motor1_word <= w1_next;
      out.motor2_word <= w2_next;
      out.motor3_word <= w3_next;
      out.quadrant    <= q3;
    end
  end

  assign out.valid = v4;

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.quadrant == tpqd_pkg::Q_NONE) |->
      (out.motor0_word == '0 && out.motor1_word == '0 &&
       out.motor2_word == '0 && out.motor3_word == '0))
    else $error("motor words not zero for no-quadrant transaction");

  a_two_dirs: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.quadrant != tpqd_pkg::Q_NONE) |->
      ($countones({out.motor0_word[tpqd_pkg::DRIVE_BITS], out.motor1_word[tpqd_pkg::DRIVE_BITS],
                   out.motor2_word[tpqd_pkg::DRIVE_BITS],
                   out.motor3_word[tpqd_pkg::DRIVE_BITS]}) == 2))
    else $error("direction bits not on exactly two motors");

  a_q1_dirs: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.quadrant == tpqd_pkg::Q_ONE) |->
      (out.motor1_word[tpqd_pkg::DRIVE_BITS] && out.motor2_word[tpqd_pkg::DRIVE_BITS]))
    else $error("quadrant one direction bits misplaced");

  a_no_empty_stall: assert property (@(posedge clk) disable iff (rst)
    !in.ready |-> (v1 && v2 && v3 && v4))
    else $error("input stalled while a stage is empty");

endmodule

`default_nettype wire

[hw/rtl/tpqd_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// One axis of the controller: error, saturating sum, three gain products, clamp.
// Three register stages; uses tpqd_pkg types and constants.

module tpqd_lane #(
  parameter int COORD_BITS   = 12,
  parameter int SUM_BITS     = 32,
  parameter int CENTER_RESET = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tpqd_pkg::pipe_ctrl_t               ctrl,
  input  wire logic [COORD_BITS-1:0]              target,
  input  wire logic [tpqd_pkg::CENTER_BITS-1:0]   center,
  input  wire tpqd_pkg::gains_t                   gains,
  output logic      [tpqd_pkg::DRIVE_BITS-1:0]    drive
);

  localparam int XW     = (COORD_BITS > tpqd_pkg::CENTER_BITS) ? COORD_BITS
                                                               : tpqd_pkg::CENTER_BITS;
  localparam int ERR_W  = XW + 1;
  localparam int LAST_W = XW + 2;
  localparam int DIFF_W = XW + 3;
  localparam int GW     = tpqd_pkg::GAIN_BITS;
  localparam int PP_W   = GW + ERR_W;
  localparam int IP_W   = GW + SUM_BITS;
  localparam int DP_W   = GW + DIFF_W;
  localparam int TOT_W  = IP_W + 2;
  localparam int DW     = tpqd_pkg::DRIVE_BITS;

  localparam logic signed [SUM_BITS-1:0] SUM_HI = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_LO = {1'b1, {(SUM_BITS-1){1'b0}}};

  logic signed [SUM_BITS-1:0] error_sum;
  logic signed [LAST_W-1:0]   last_error;

  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_BITS:0]   sum_wide;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic signed [ERR_W-1:0]    mag_next;
  logic signed [DIFF_W-1:0]   diff_next;

  logic signed [ERR_W-1:0]    mag;
  logic signed [SUM_BITS-1:0] sum_s1;
  logic signed [DIFF_W-1:0]   diff;

  logic signed [PP_W-1:0]     p_prod;
  logic signed [IP_W-1:0]     i_prod;
  logic signed [DP_W-1:0]     d_prod;

  logic signed [TOT_W-1:0]    total;
  logic signed [TOT_W-1:0]    scaled;
  logic        [DW-1:0]       drive_next;

  always_comb begin
    err       = $signed({1'b0, XW'(target)}) - $signed({1'b0, XW'(center)});
    sum_wide  = (SUM_BITS+1)'(error_sum) + (SUM_BITS+1)'(err);
    if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
      sum_sat = sum_wide[SUM_BITS] ? SUM_LO : SUM_HI;
    end else begin
      sum_sat = sum_wide[SUM_BITS-1:0];
    end
    mag_next  = err[ERR_W-1] ? -err : err;
    diff_next = DIFF_W'(last_error) - DIFF_W'(err);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      last_error <= LAST_W'(CENTER_RESET);
    end else if (ctrl.acc) begin
      error_sum  <= sum_sat;
      last_error <= LAST_W'(err);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.e1) begin
      mag    <= mag_next;
      sum_s1 <= sum_sat;
      diff   <= diff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.e2) begin
      p_prod <= PP_W'(gains.p) * PP_W'(mag);
      i_prod <= IP_W'(gains.i) * IP_W'(sum_s1);
      d_prod <= DP_W'(gains.d) * DP_W'(diff);
    end
  end

  always_comb begin
    total  = TOT_W'(p_prod) + TOT_W'(i_prod) + TOT_W'(d_prod);
    scaled = total >>> tpqd_pkg::FRAC_BITS;
    if (total[TOT_W-1] || total == '0) begin
      drive_next = '0;
    end else if (scaled[TOT_W-1:DW] != '0) begin
      drive_next = tpqd_pkg::DRIVE_MAX;
    end else begin
      drive_next = scaled[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.e3) begin
      drive <= drive_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpqd_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// Combines the two axis drives into four motor words by quadrant.
// Uses tpqd_pkg for the quadrant code and widths.

module tpqd_merge (
  input  wire logic [tpqd_pkg::DRIVE_BITS-1:0] drive_x,
  input  wire logic [tpqd_pkg::DRIVE_BITS-1:0] drive_y,
  input  wire tpqd_pkg::quad_t                 quad,
  output logic      [tpqd_pkg::WORD_BITS-1:0]  word0,
  output logic      [tpqd_pkg::WORD_BITS-1:0]  word1,
  output logic      [tpqd_pkg::WORD_BITS-1:0]  word2,
  output logic      [tpqd_pkg::WORD_BITS-1:0]  word3
);

  always_comb begin
    word0 = {1'b0, drive_y};
    word1 = {1'b0, drive_y};
    word2 = {1'b0, drive_x};
    word3 = {1'b0, drive_x};
    unique case (quad)
      tpqd_pkg::Q_ONE: begin
        word1 = {1'b1, drive_y};
        word2 = {1'b1, drive_x};
      end
      tpqd_pkg::Q_TWO: begin
        word1 = {1'b1, drive_y};
        word3 = {1'b1, drive_x};
      end
      tpqd_pkg::Q_THREE: begin
        word0 = {1'b1, drive_y};
        word3 = {1'b1, drive_x};
      end
      tpqd_pkg::Q_FOUR: begin
        word0 = {1'b1, drive_y};
        word2 = {1'b1, drive_x};
      end
      default: begin
        word0 = '0;
        word1 = '0;
        word2 = '0;
        word3 = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[dv/two_axis_pid_quadrant_drive_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for the two-axis PID quadrant drive: a directed table, random
// gains and targets under three handshake idling mixes, then an integral-only full-error run.
// Depends on tpqd_pkg, tpqd_in_if, tpqd_out_if and two_axis_pid_quadrant_drive_unit.

module two_axis_pid_quadrant_drive_unit_test;

  localparam int COORD_BITS = 12;
  localparam int SUM_BITS = 32;
  localparam int COORD_TOP = (1 << COORD_BITS) - 1;
  localparam longint SUM_TOP = (longint'(1) <<< (SUM_BITS - 1)) - 1;
  localparam longint SUM_BOTTOM = -SUM_TOP - 1;
  localparam logic [tpqd_pkg::WORD_BITS-1:0] DIR_BIT = 11'd1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [tpqd_pkg::WORD_BITS-1:0] m0;
    logic [tpqd_pkg::WORD_BITS-1:0] m1;
    logic [tpqd_pkg::WORD_BITS-1:0] m2;
    logic [tpqd_pkg::WORD_BITS-1:0] m3;
    tpqd_pkg::quad_t                quad;
  } words_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_ITEM,
    ROW_KNOWN
  } row_kind_t;

  typedef struct {
    row_kind_t                     kind;
    tpqd_pkg::reg_index_t          idx;
    logic [tpqd_pkg::CFG_BITS-1:0] data;
    coord_t                        tx;
    coord_t                        ty;
    logic                          en;
    words_t                        want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [tpqd_pkg::INDEX_BITS-1:0] cfg_index;
  logic [tpqd_pkg::CFG_BITS-1:0] cfg_data;

  tpqd_in_if #(.COORD_BITS(COORD_BITS)) target_ch ();
  tpqd_out_if drive_ch ();

  two_axis_pid_quadrant_drive_unit #(
    .COORD_BITS(COORD_BITS),
    .SUM_BITS(SUM_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in(target_ch),
    .out(drive_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // controller copy: set points, gains, running sums and last errors (x = 0, y = 1)
  logic [tpqd_pkg::CENTER_BITS-1:0] set_x;
  logic [tpqd_pkg::CENTER_BITS-1:0] set_y;
  shortint kp;
  shortint ki;
  shortint kd;
  longint err_sum [2];
  int prev_err [2];

  words_t pending_drive_words [$];
  row_t script [$];
  int mismatch_count = 0;
  int src_gap = 33;
  int sink_gap = 87;
  int stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    drive_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      drive_ch.ready <= ($urandom_range(0, 99) >= sink_gap);
    end
  end

  function automatic logic [tpqd_pkg::DRIVE_BITS-1:0] axis_speed(input int axis,
                                                                 input int err);
    longint acc;
    longint mag;
    longint total;
    acc = err_sum[axis] + err;
    if (acc > SUM_TOP) acc = SUM_TOP;
    if (acc < SUM_BOTTOM) acc = SUM_BOTTOM;
    mag = (err < 0) ? -longint'(err) : longint'(err);
    total = longint'(kp) * mag + longint'(ki) * acc
          + longint'(kd) * (longint'(prev_err[axis]) - longint'(err));
    err_sum[axis] = acc;
    prev_err[axis] = err;
    if (total <= 0) return '0;
    total = total >>> tpqd_pkg::FRAC_BITS;
    if (total > longint'(tpqd_pkg::DRIVE_MAX)) return tpqd_pkg::DRIVE_MAX;
    return total[tpqd_pkg::DRIVE_BITS-1:0];
  endfunction

  function automatic words_t expected_drive_words(coord_t tx, coord_t ty, logic en);
    logic [tpqd_pkg::DRIVE_BITS-1:0] sx;
    logic [tpqd_pkg::DRIVE_BITS-1:0] sy;
    tpqd_pkg::quad_t q;
    words_t w;
    w = '0;
    if (!en) return w;
    sx = axis_speed(0, int'(tx) - int'(set_x));
    sy = axis_speed(1, int'(ty) - int'(set_y));
    if (tx >= set_x && ty >= set_y) q = tpqd_pkg::Q_ONE;
    else if (tx < set_x && ty > set_y) q = tpqd_pkg::Q_TWO;
    else if (tx <= set_x && ty <= set_y) q = tpqd_pkg::Q_THREE;
    else if (tx > set_x && ty < set_y) q = tpqd_pkg::Q_FOUR;
    else q = tpqd_pkg::Q_NONE;
    w.m0 = {1'b0, sy};
    w.m1 = {1'b0, sy};
    w.m2 = {1'b0, sx};
    w.m3 = {1'b0, sx};
    case (q)
      tpqd_pkg::Q_ONE: begin
        w.m1 = w.m1 + DIR_BIT;
        w.m2 = w.m2 + DIR_BIT;
      end
      tpqd_pkg::Q_TWO: begin
        w.m1 = w.m1 + DIR_BIT;
        w.m3 = w.m3 + DIR_BIT;
      end
      tpqd_pkg::Q_THREE: begin
        w.m0 = w.m0 + DIR_BIT;
        w.m3 = w.m3 + DIR_BIT;
      end
      tpqd_pkg::Q_FOUR: begin
        w.m0 = w.m0 + DIR_BIT;
        w.m2 = w.m2 + DIR_BIT;
      end
      default: begin
        w = '0;
      end
    endcase
    w.quad = q;
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_drive_words(words_t got);
    words_t want;
    if (pending_drive_words.size() == 0) begin
      report_mismatch("drive transaction with none pending", int'(got.quad), 0);
      return;
    end
    want = pending_drive_words.pop_front();
    if (got.m0 !== want.m0) report_mismatch("motor0_word", int'(got.m0), int'(want.m0));
    if (got.m1 !== want.m1) report_mismatch("motor1_word", int'(got.m1), int'(want.m1));
    if (got.m2 !== want.m2) report_mismatch("motor2_word", int'(got.m2), int'(want.m2));
    if (got.m3 !== want.m3) report_mismatch("motor3_word", int'(got.m3), int'(want.m3));
    if (got.quad !== want.quad) report_mismatch("quadrant", int'(got.quad), int'(want.quad));
  endtask

  always @(posedge clk) begin
    words_t got;
    if (!rst && drive_ch.valid && drive_ch.ready) begin
      got.m0 = drive_ch.motor0_word;
      got.m1 = drive_ch.motor1_word;
      got.m2 = drive_ch.motor2_word;
      got.m3 = drive_ch.motor3_word;
      got.quad = tpqd_pkg::quad_t'(drive_ch.quadrant);
      check_drive_words(got);
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (target_ch.valid && target_ch.ready) || (drive_ch.valid && drive_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_target(coord_t tx, coord_t ty, logic en, bit known, words_t want);
    words_t predicted;
    while ($urandom_range(0, 99) < src_gap) begin
      target_ch.valid <= 1'b0;
      @(posedge clk);
    end
    target_ch.valid <= 1'b1;
    target_ch.target_x <= tx;
    target_ch.target_y <= ty;
    target_ch.drive_enable <= en;
    @(posedge clk);
    while (!target_ch.ready) @(posedge clk);
    predicted = expected_drive_words(tx, ty, en);
    pending_drive_words.push_back(known ? want : predicted);
  endtask

  task automatic settle_pipeline();
    target_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_drive_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(tpqd_pkg::reg_index_t idx,
                                logic [tpqd_pkg::CFG_BITS-1:0] data);
    settle_pipeline();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tpqd_pkg::REG_CENTER_X: set_x = data[tpqd_pkg::CENTER_BITS-1:0];
      tpqd_pkg::REG_CENTER_Y: set_y = data[tpqd_pkg::CENTER_BITS-1:0];
      tpqd_pkg::REG_GAIN_P: kp = $signed(data);
      tpqd_pkg::REG_GAIN_I: ki = $signed(data);
      tpqd_pkg::REG_GAIN_D: kd = $signed(data);
      default: ;
    endcase
  endtask

  function automatic void add_reg(tpqd_pkg::reg_index_t idx,
                                  logic [tpqd_pkg::CFG_BITS-1:0] data);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, data: data, tx: '0, ty: '0, en: 1'b0, want: '0};
    script.push_back(r);
  endfunction

  function automatic void add_item(coord_t tx, coord_t ty, logic en);
    row_t r;
    r = '{kind: ROW_ITEM, idx: tpqd_pkg::REG_CENTER_X, data: '0, tx: tx, ty: ty, en: en,
          want: '0};
    script.push_back(r);
  endfunction

  function automatic void add_known(coord_t tx, coord_t ty, logic en, int m0, int m1,
                                    int m2, int m3, tpqd_pkg::quad_t q);
    row_t r;
    words_t w;
    w.m0 = m0[tpqd_pkg::WORD_BITS-1:0];
    w.m1 = m1[tpqd_pkg::WORD_BITS-1:0];
    w.m2 = m2[tpqd_pkg::WORD_BITS-1:0];
    w.m3 = m3[tpqd_pkg::WORD_BITS-1:0];
    w.quad = q;
    r = '{kind: ROW_KNOWN, idx: tpqd_pkg::REG_CENTER_X, data: '0, tx: tx, ty: ty, en: en,
          want: w};
    script.push_back(r);
  endfunction

  function automatic logic [tpqd_pkg::CFG_BITS-1:0] random_gain(int span);
    int pick;
    int mag;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'h8000;
    if (pick == 1) return 16'h7FFF;
    if (pick == 2) return 16'h0000;
    if (pick == 3) return 16'($urandom);
    mag = $urandom_range(0, span);
    return (pick % 2) ? 16'(mag) : 16'(-mag);
  endfunction

  function automatic logic [tpqd_pkg::CFG_BITS-1:0] random_center();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 16'(COORD_TOP);
      2: return 16'($urandom);
      default: return 16'($urandom_range(256, 3840));
    endcase
  endfunction

  function automatic coord_t random_coord(logic [tpqd_pkg::CENTER_BITS-1:0] mid);
    int v;
    case ($urandom_range(0, 7))
      0: return mid;
      1: return coord_t'($urandom);
      2: return ($urandom_range(0, 1) != 0) ? coord_t'(COORD_TOP) : '0;
      default: v = int'(mid) + int'($urandom_range(0, 128)) - 64;
    endcase
    if (v < 0) v = 0;
    if (v > COORD_TOP) v = COORD_TOP;
    return coord_t'(v);
  endfunction

  initial begin
    coord_t tx;
    coord_t ty;
    logic en;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tpqd_pkg::REG_CENTER_X;
    cfg_data = '0;
    target_ch.valid = 1'b0;
    target_ch.target_x = '0;
    target_ch.target_y = '0;
    target_ch.drive_enable = 1'b0;
    set_x = tpqd_pkg::CENTER_X_RESET;
    set_y = tpqd_pkg::CENTER_Y_RESET;
    kp = $signed(tpqd_pkg::GAIN_P_RESET);
    ki = $signed(tpqd_pkg::GAIN_I_RESET);
    kd = $signed(tpqd_pkg::GAIN_D_RESET);
    err_sum[0] = 0;
    err_sum[1] = 0;
    prev_err[0] = int'(tpqd_pkg::CENTER_X_RESET);
    prev_err[1] = int'(tpqd_pkg::CENTER_Y_RESET);

    // reset gains give drive = min(|error|, 1023); last errors start at the set points
    add_known(100, 50, 1'b0, 0, 0, 0, 0, tpqd_pkg::Q_NONE);
    add_reg(tpqd_pkg::REG_GAIN_D, 16'h0100);
    add_known(320, 240, 1'b1, 240, 1264, 1344, 320, tpqd_pkg::Q_ONE);
    add_reg(tpqd_pkg::REG_GAIN_D, 16'h0000);
    add_known(0, 0, 1'b1, 1264, 240, 320, 1344, tpqd_pkg::Q_THREE);
    add_known(4095, 4095, 1'b1, 1023, 2047, 2047, 1023, tpqd_pkg::Q_ONE);
    add_known(0, 4095, 1'b1, 1023, 2047, 320, 1344, tpqd_pkg::Q_TWO);
    add_known(4095, 0, 1'b1, 1264, 240, 2047, 1023, tpqd_pkg::Q_FOUR);
    add_known(320, 0, 1'b1, 1264, 240, 0, 1024, tpqd_pkg::Q_THREE);
    add_known(0, 240, 1'b1, 1024, 0, 320, 1344, tpqd_pkg::Q_THREE);
    add_known(4095, 240, 1'b1, 0, 1024, 2047, 1023, tpqd_pkg::Q_ONE);
    add_known(320, 4095, 1'b1, 1023, 2047, 1024, 0, tpqd_pkg::Q_ONE);
    add_known(321, 239, 1'b1, 1025, 1, 1025, 1, tpqd_pkg::Q_FOUR);
    add_known(4095, 0, 1'b0, 0, 0, 0, 0, tpqd_pkg::Q_NONE);
    add_reg(tpqd_pkg::REG_GAIN_P, 16'h8000);
    add_reg(tpqd_pkg::REG_GAIN_I, 16'h7FFF);
    add_reg(tpqd_pkg::REG_GAIN_D, 16'h8000);
    add_item(0, 4095, 1'b1);
    add_item(4095, 0, 1'b1);
    add_item(2048, 2048, 1'b1);
    add_reg(tpqd_pkg::REG_CENTER_X, 16'h0000);
    add_reg(tpqd_pkg::REG_CENTER_Y, 16'hFFFF);
    add_reg(tpqd_pkg::REG_GAIN_P, 16'h7FFF);
    add_reg(tpqd_pkg::REG_GAIN_I, 16'h8000);
    add_reg(tpqd_pkg::REG_GAIN_D, 16'h7FFF);
    add_item(0, 4095, 1'b1);
    add_item(4095, 0, 1'b1);
    add_item(0, 0, 1'b0);
    add_item(2730, 1365, 1'b1);
    add_reg(tpqd_pkg::REG_CENTER_X, 16'h0FFF);
    add_reg(tpqd_pkg::REG_CENTER_Y, 16'h0000);
    add_reg(tpqd_pkg::REG_GAIN_P, 16'h0080);
    add_reg(tpqd_pkg::REG_GAIN_I, 16'h0000);
    add_reg(tpqd_pkg::REG_GAIN_D, 16'h0000);
    add_item(4094, 1, 1'b1);
    add_item(4092, 3, 1'b1);
    add_item(4095, 0, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      case (script[k].kind)
        ROW_REG: write_register(script[k].idx, script[k].data);
        ROW_ITEM: send_target(script[k].tx, script[k].ty, script[k].en, 1'b0, '0);
        default: send_target(script[k].tx, script[k].ty, script[k].en, 1'b1, script[k].want);
      endcase
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_gap = 33;
          sink_gap = 87;
        end
        1: begin
          src_gap = 87;
          sink_gap = 33;
        end
        default: begin
          src_gap = 0;
          sink_gap = 0;
        end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        write_register(tpqd_pkg::REG_CENTER_X, random_center());
        write_register(tpqd_pkg::REG_CENTER_Y, random_center());
        write_register(tpqd_pkg::REG_GAIN_P, random_gain(768));
        write_register(tpqd_pkg::REG_GAIN_I, random_gain(8));
        write_register(tpqd_pkg::REG_GAIN_D, random_gain(768));
        for (int n = 0; n < 170; n++) begin
          tx = random_coord(set_x);
          ty = random_coord(set_y);
          en = ($urandom_range(0, 9) != 0);
          send_target(tx, ty, en, 1'b0, '0);
          // hold the sender until every drive transaction is back
          if ($urandom_range(0, 149) == 0) settle_pipeline();
        end
      end
    end

    // push x sum up and y sum down at full error with the integral gain alone
    write_register(tpqd_pkg::REG_CENTER_X, 16'h0000);
    write_register(tpqd_pkg::REG_CENTER_Y, 16'(COORD_TOP));
    write_register(tpqd_pkg::REG_GAIN_P, 16'h0000);
    write_register(tpqd_pkg::REG_GAIN_I, 16'h0001);
    write_register(tpqd_pkg::REG_GAIN_D, 16'h0000);
    for (int n = 0; n < 64; n++)
      send_target(coord_t'(COORD_TOP), '0, 1'b1, 1'b0, '0);

    settle_pipeline();
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
